[hdl/sdf_pkg.sv]
package sdf_pkg;

   localparam int AXIS_COUNT_DEF = 6;
   localparam int IN_AXES        = 6;
   localparam int HDR_LEN        = 11;
   localparam int BODY_START     = 4;
   localparam int MAGIC_LEN      = 4;
   localparam int TS_POS         = 4;
   localparam int SEQ_POS        = 8;
   localparam int ID_POS         = 10;

   localparam logic [7:0] UNIT_ID_RST = 8'd2;

   localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h49, 8'h4D, 8'h55, 8'h44};

   // per-cycle controls for the byte cells
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // per-cycle controls for the checksum accumulator
   typedef struct packed {
      logic clear;
      logic add;
      logic high;
   } csum_ctrl_type;

endpackage

[hdl/sdf_ifs.sv]
interface sdf_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        sample_ms;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;

   modport source (output valid, sample_ms, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, input ready);
   modport sink (input valid, sample_ms, accel_x, accel_y, accel_z,
                 gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface sdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

[hdl/sdf_cell.sv]
module sdf_cell (
   input  logic                  clock,
   input  sdf_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]            load_byte,
   input  logic [7:0]            next_byte,
   output logic [7:0]            byte_q
);
   import sdf_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.load) begin
         byte_in = load_byte;
      end else if (ctrl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_q = byte_ff;

endmodule

[hdl/sdf_csum.sv]
module sdf_csum (
   input  logic                  clock,
   input  sdf_pkg::csum_ctrl_type ctrl,
   input  logic [7:0]            data_byte,
   output logic [15:0]           sum_q
);
   import sdf_pkg::*;

   logic [15:0] sum_ff;
   logic [15:0] sum_in;
   logic [15:0] addend;
   logic [16:0] raw;

   // ones' complement add with end-around carry; cannot carry twice
   always_comb begin
      addend = ctrl.high ? {data_byte, 8'h00} : {8'h00, data_byte};
      raw    = {1'b0, sum_ff} + {1'b0, addend};
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.add) begin
         sum_in = raw[15:0] + {15'd0, raw[16]};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum_q = sum_ff;

endmodule

[hdl/sensor_datagram_framer_top.sv]
// channel   | dir | handshake          | payload
// req_ch    | in  | valid/ready        | sample_ms, accel_x..z, gyro_x..z
// rsp_ch    | out | valid/ready        | frame_byte, frame_end
// csr       | in  | csr_we (no ready)  | csr_wdata = unit id
//
// A datagram is 13 + 2*AXIS_COUNT bytes (25 by default), one byte per cycle while rsp_ch is
// ready, from a chain of byte cells that shifts toward the output on every taken byte. A
// one-item holding register takes the next sample while one streams and loads the chain as
// the final byte is taken, so back-to-back samples follow with no gap; into an idle block a
// sample passes through the holding register and then the chain before its first byte is
// offered. The checksum sums body bytes as they leave the chain. Output stalls freeze the
// chain; synchronous reset clears control, the sequence count and the unit id (to 2).
module sensor_datagram_framer_top #(
   parameter int AXIS_COUNT = sdf_pkg::AXIS_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sdf_req_if.sink    req_ch,
   sdf_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import sdf_pkg::*;

   localparam int FRAME_LEN = HDR_LEN + 2 * AXIS_COUNT + 2;
   localparam int DATA_LEN  = FRAME_LEN - 2;
   localparam int POS_W     = $clog2(FRAME_LEN);

   logic [7:0]  unit_id_ff;
   logic [15:0] seq_ff;
   logic [15:0] seq_in;
   logic        pend_valid_ff;
   logic        pend_valid_in;
   logic        busy_ff;
   logic        busy_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;

   logic [31:0] pend_ts_ff;
   logic [15:0] pend_axis_ff [IN_AXES];

   logic req_fire;
   logic rsp_fire;
   logic last_fire;
   logic load;

   logic [7:0] load_bytes [DATA_LEN];
   logic [7:0] cell_q     [DATA_LEN];
   logic [15:0] sum_q;

   cell_ctrl_type cell_ctrl;
   csum_ctrl_type csum_ctrl;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign last_fire = rsp_fire && (pos_ff == POS_W'(FRAME_LEN - 1));
   assign load      = pend_valid_ff && (!busy_ff || last_fire);

   assign req_ch.ready = !pend_valid_ff || load;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_fire) begin
         pend_valid_in = 1'b1;
      end else if (load) begin
         pend_valid_in = 1'b0;
      end
      busy_in = busy_ff;
      pos_in  = pos_ff;
      seq_in  = seq_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
         seq_in  = seq_ff + 16'd1;
      end else if (last_fire) begin
         busy_in = 1'b0;
         pos_in  = '0;
      end else if (rsp_fire) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff    <= UNIT_ID_RST;
         seq_ff        <= '0;
         pend_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         pos_ff        <= '0;
      end else begin
         if (csr_we) begin
            unit_id_ff <= csr_wdata;
         end
         seq_ff        <= seq_in;
         pend_valid_ff <= pend_valid_in;
         busy_ff       <= busy_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_ts_ff      <= req_ch.sample_ms;
         pend_axis_ff[0] <= req_ch.accel_x;
         pend_axis_ff[1] <= req_ch.accel_y;
         pend_axis_ff[2] <= req_ch.accel_z;
         pend_axis_ff[3] <= req_ch.gyro_x;
         pend_axis_ff[4] <= req_ch.gyro_y;
         pend_axis_ff[5] <= req_ch.gyro_z;
      end
   end

   // datagram image without the checksum
   genvar gi;
   generate
      for (gi = 0; gi < MAGIC_LEN; gi++) begin : g_magic
         assign load_bytes[gi] = MAGIC[gi];
      end
      for (gi = 0; gi < 4; gi++) begin : g_ts
         assign load_bytes[TS_POS + gi] = pend_ts_ff[8*gi +: 8];
      end
      assign load_bytes[SEQ_POS]     = seq_ff[7:0];
      assign load_bytes[SEQ_POS + 1] = seq_ff[15:8];
      assign load_bytes[ID_POS]      = unit_id_ff;
      for (gi = 0; gi < AXIS_COUNT; gi++) begin : g_axis
         if (gi < IN_AXES) begin : g_in
            assign load_bytes[HDR_LEN + 2*gi]     = pend_axis_ff[gi][7:0];
            assign load_bytes[HDR_LEN + 2*gi + 1] = pend_axis_ff[gi][15:8];
         end else begin : g_zero
            assign load_bytes[HDR_LEN + 2*gi]     = 8'h00;
            assign load_bytes[HDR_LEN + 2*gi + 1] = 8'h00;
         end
      end
   endgenerate

   assign cell_ctrl.load  = load;
   assign cell_ctrl.shift = rsp_fire;

   generate
      for (gi = 0; gi < DATA_LEN; gi++) begin : g_cell
         if (gi < DATA_LEN - 1) begin : g_mid
            sdf_cell u_cell (
               .clock     (clock),
               .ctrl      (cell_ctrl),
               .load_byte (load_bytes[gi]),
               .next_byte (cell_q[gi+1]),
               .byte_q    (cell_q[gi])
            );
         end else begin : g_tail
            sdf_cell u_cell (
               .clock     (clock),
               .ctrl      (cell_ctrl),
               .load_byte (load_bytes[gi]),
               .next_byte (8'h00),
               .byte_q    (cell_q[gi])
            );
         end
      end
   endgenerate

   // body starts on an even position, so even positions are word high bytes
   assign csum_ctrl.clear = load;
   assign csum_ctrl.add   = rsp_fire && (pos_ff >= POS_W'(BODY_START))
                            && (pos_ff < POS_W'(DATA_LEN));
   assign csum_ctrl.high  = !pos_ff[0];

   sdf_csum u_csum (
      .clock     (clock),
      .ctrl      (csum_ctrl),
      .data_byte (cell_q[0]),
      .sum_q     (sum_q)
   );

   always_comb begin
      if (pos_ff < POS_W'(DATA_LEN)) begin
         rsp_ch.frame_byte = cell_q[0];
      end else if (pos_ff == POS_W'(DATA_LEN)) begin
         rsp_ch.frame_byte = ~sum_q[7:0];
      end else begin
         rsp_ch.frame_byte = ~sum_q[15:8];
      end
   end

   assign rsp_ch.frame_end = (pos_ff == POS_W'(FRAME_LEN - 1));
   assign rsp_ch.valid     = busy_ff;

endmodule

[tb/tb_sensor_datagram_framer_top.sv]
module tb_sensor_datagram_framer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sdf_pkg::*;

   localparam int AXIS_N    = AXIS_COUNT_DEF;
   localparam int FRAME_LEN = HDR_LEN + 2 * AXIS_N + 2;
   localparam int RUN_LIMIT = 3_000_000;

   typedef struct {
      bit [31:0] ts;
      bit [15:0] axis [IN_AXES];
   } sample_type;

   typedef struct {
      bit [7:0] value;
      bit       last;
      int       pos;
   } frame_entry_type;

   typedef bit [7:0] frame_type [FRAME_LEN];

   class datagram_scoreboard;
      bit [7:0]        unit_id;
      bit [15:0]       seq_count;
      frame_entry_type pending_bytes [$];
      int              mismatches;
      int              bytes_checked;
      int              datagrams;

      function new();
         unit_id   = UNIT_ID_RST;
         seq_count = '0;
      endfunction

      // build the datagram for the current sequence number and unit id
      function void predict_datagram(input sample_type s, output frame_type f);
         bit [31:0] acc;
         bit [15:0] w;
         int        k;
         for (k = 0; k < MAGIC_LEN; k++) f[k] = MAGIC[k];
         f[TS_POS]      = s.ts[7:0];
         f[TS_POS + 1]  = s.ts[15:8];
         f[TS_POS + 2]  = s.ts[23:16];
         f[TS_POS + 3]  = s.ts[31:24];
         f[SEQ_POS]     = seq_count[7:0];
         f[SEQ_POS + 1] = seq_count[15:8];
         f[ID_POS]      = unit_id;
         for (k = 0; k < AXIS_N; k++) begin
            w = (k < IN_AXES) ? s.axis[k] : 16'h0000;
            f[HDR_LEN + 2 * k]     = w[7:0];
            f[HDR_LEN + 2 * k + 1] = w[15:8];
         end
         // big-endian words over the body, odd tail byte in the high half
         acc = '0;
         for (k = BODY_START; k + 1 < FRAME_LEN - 2; k += 2) acc += {f[k], f[k + 1]};
         if (k < FRAME_LEN - 2) acc += {f[k], 8'h00};
         while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
         w = ~acc[15:0];
         f[FRAME_LEN - 2] = w[7:0];
         f[FRAME_LEN - 1] = w[15:8];
      endfunction

      function void note_sample(input sample_type s);
         frame_type       f;
         frame_entry_type x;
         predict_datagram(s, f);
         for (int k = 0; k < FRAME_LEN; k++) begin
            x.value = f[k];
            x.last  = (k == FRAME_LEN - 1);
            x.pos   = k;
            pending_bytes.push_back(x);
         end
         seq_count++;
         datagrams++;
      endfunction

      function void check_byte(input logic [7:0] b, input logic e);
         frame_entry_type x;
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected byte %02h end=%b, nothing pending", $realtime, b, e);
            return;
         end
         x = pending_bytes.pop_front();
         bytes_checked++;
         if (b !== x.value || e !== x.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: byte %0d: expected %02h end=%0b, got %02h end=%b",
                        $realtime, x.pos, x.value, x.last, b, e);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;
   bit         quiet;
   int         id_writes;

   sdf_req_if req_ch ();
   sdf_rsp_if rsp_ch ();

   datagram_scoreboard sb;

   sensor_datagram_framer_top #(.AXIS_COUNT(AXIS_N)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [15:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      s.ts = {rand_word(), rand_word()};
      for (int a = 0; a < IN_AXES; a++) s.axis[a] = rand_word();
      return s;
   endfunction

   function automatic sample_type make_sample(bit [31:0] ts, bit [15:0] v);
      sample_type s;
      s.ts = ts;
      for (int a = 0; a < IN_AXES; a++) s.axis[a] = v;
      return s;
   endfunction

   // gyro_z lands as its own value in the sum (low byte ends a word, high byte
   // is the padded tail), so setting it to the checksum of the rest yields 0
   function automatic sample_type zero_checksum(sample_type s);
      frame_type f;
      s.axis[IN_AXES - 1] = '0;
      sb.predict_datagram(s, f);
      s.axis[IN_AXES - 1] = {f[FRAME_LEN - 1], f[FRAME_LEN - 2]};
      return s;
   endfunction

   task automatic send_sample(sample_type s, int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.sample_ms <= s.ts;
      req_ch.accel_x   <= s.axis[0];
      req_ch.accel_y   <= s.axis[1];
      req_ch.accel_z   <= s.axis[2];
      req_ch.gyro_x    <= s.axis[3];
      req_ch.gyro_y    <= s.axis[4];
      req_ch.gyro_z    <= s.axis[5];
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(s);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_unit_id(bit [7:0] v);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.unit_id = v;
      id_writes++;
   endtask

   // result side: random stalls, none while quiet
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet) stall = rand_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_byte(rsp_ch.frame_byte, rsp_ch.frame_end);
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("timeout: %0d bytes still pending", sb.pending_bytes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      sample_type s;
      bit [7:0] ids [6];
      sb = new();
      quiet     = 1'b0;
      id_writes = 0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample_ms = '0;
      req_ch.accel_x   = '0;
      req_ch.accel_y   = '0;
      req_ch.accel_z   = '0;
      req_ch.gyro_x    = '0;
      req_ch.gyro_y    = '0;
      req_ch.gyro_z    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset unit id, field extremes
      send_sample(make_sample(32'h0000_0000, 16'h0000), 0);
      send_sample(make_sample(32'hFFFF_FFFF, 16'hFFFF), 0);
      send_sample(make_sample(32'h7FFF_FFFF, 16'h7FFF), 2);
      send_sample(make_sample(32'h8000_0000, 16'h8000), 0);

      write_unit_id(8'hFF);
      s = make_sample(32'hA5A5_A5A5, 16'hAAAA);
      s.axis[1] = 16'h5555;
      s.axis[3] = 16'h5555;
      s.axis[5] = 16'h5555;
      send_sample(s, 0);
      send_sample(zero_checksum(make_sample(32'h1234_5678, 16'hFFFF)), 0);
      s = make_sample(32'h0000_0001, 16'h0001);
      for (int a = 1; a < IN_AXES; a++) s.axis[a] = 16'h0001 << (3 * a);
      send_sample(s, 0);

      write_unit_id(8'h00);
      send_sample(make_sample(32'h0000_0000, 16'h0000), 0);
      send_sample(zero_checksum(make_sample(32'hFFFF_FFFF, 16'h7FFF)), 1);
      s = make_sample(32'h0001_0000, 16'h8000);
      s.axis[1] = 16'h7FFF;
      s.axis[2] = 16'hFFFF;
      s.axis[4] = 16'h0001;
      send_sample(s, 0);

      // full rate with no output stalls
      quiet = 1'b1;
      send_sample(make_sample(32'hFFFF_FFFF, 16'hFFFF), 0);
      send_sample(zero_checksum(make_sample(32'hDEAD_BEEF, 16'h8000)), 0);
      send_sample(make_sample(32'h0000_0000, 16'h0000), 0);
      quiet = 1'b0;

      ids[0] = 8'hFF;
      ids[1] = 8'h00;
      ids[2] = 8'($urandom);
      ids[3] = 8'($urandom);
      ids[4] = 8'h80;
      ids[5] = 8'($urandom);
      for (int p = 0; p < 6; p++) begin
         write_unit_id(ids[p]);
         quiet = (p == 2);
         for (int k = 0; k < 58; k++) begin
            if (p == 3 && k == 30) drain();
            send_sample(rand_sample(), quiet ? 0 : rand_gap());
         end
      end
      quiet = 1'b0;

      drain();
      repeat (3 * FRAME_LEN) @(posedge clock);

      $display("%0d datagrams, %0d bytes checked, %0d unit id writes",
               sb.datagrams, sb.bytes_checked, id_writes);
      $display("field extremes, zero checksum, unit id changes, random stalls on both sides");
      if (sb.pending_bytes.size() != 0)
         $display("%0d expected bytes never arrived", sb.pending_bytes.size());
      if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
